FILE: hdl/aes128_cbc_engine_core_macros.svh
// assertion macros for the aes128 cbc engine checker
`ifndef AES128_CBC_ENGINE_CORE_MACROS_SVH
`define AES128_CBC_ENGINE_CORE_MACROS_SVH
`define ACE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ACE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: hdl/aes_pkg.sv
// shared types, constants and round functions for the aes128 cbc engine
`default_nettype none
package aes_pkg;
  localparam int unsigned HalfW = 64;
  localparam int unsigned RkDepth = 44;
  localparam int unsigned RkAw = 6;

  typedef enum logic [1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_IV_HIGH  = 2'd2,
    REG_IV_LOW   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic        mode;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        restart_chain;
    logic        last_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        result_last;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load;       // capture input item and chain state
    logic       key_init;   // load key words 0..3
    logic       key_step;   // compute one schedule word
    logic       rk_rd;      // request round key read
    logic [3:0] rk_round;   // round key index to read
    logic       add_first;  // initial key add
    logic       round_en;   // apply one round
    logic       final_rnd;  // round without mixcolumns
    logic       finish;     // cbc xor and chain update
  } ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  localparam logic [7:0] SBOX_AFFINE = 8'h63;

  function automatic logic [7:0] sub_byte(input logic [7:0] a);
    sub_byte = SBOX[a];
  endfunction

  // inverse table derived from the forward table by search
  function automatic logic [7:0] inv_sub_byte(input logic [7:0] a);
    logic [7:0] r;
    r = 8'h00;
    for (int n = 0; n < 256; n++) begin
      if (SBOX[n] == a) r = 8'(n);
    end
    inv_sub_byte = r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // state is 16 bytes, byte 0 at [127:120], column major
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic fwd);
    logic [127:0] t;
    int src;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = fwd ? ((c + r) & 3) : ((c - r + 4) & 3);
        t[127 - 8*(c*4+r) -: 8] = s[127 - 8*(src*4+r) -: 8];
      end
    end
    shift_rows = t;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] col, input logic fwd);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m [4][4];
    logic [31:0] o;
    o = '0;
    for (int k = 0; k < 4; k++) begin
      a[k]  = col[31 - 8*k -: 8];
      x2[k] = xt(a[k]);
      x4[k] = xt(x2[k]);
      x8[k] = xt(x4[k]);
      m[k][0] = fwd ? x2[k] : (x8[k] ^ x4[k] ^ x2[k]);         // 2 or 0e
      m[k][1] = fwd ? (x2[k] ^ a[k]) : (x8[k] ^ x2[k] ^ a[k]); // 3 or 0b
      m[k][2] = fwd ? a[k] : (x8[k] ^ x4[k] ^ a[k]);          // 1 or 0d
      m[k][3] = fwd ? a[k] : (x8[k] ^ a[k]);                  // 1 or 09
    end
    for (int r = 0; r < 4; r++) begin
      o[31 - 8*r -: 8] = m[0][(0 - r + 4) & 3] ^ m[1][(1 - r + 4) & 3]
                       ^ m[2][(2 - r + 4) & 3] ^ m[3][(3 - r + 4) & 3];
    end
    mix_col = o;
  endfunction
endpackage
`default_nettype wire

FILE: hdl/aes_ram.sv
// generic ram with one write port, one read port and registered read
`default_nettype none
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 44
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/aes_datapath.sv
// aes round datapath, key schedule and cbc chaining registers
`default_nettype none
module aes_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire aes_pkg::ctl_t     ctl,
  input  wire aes_pkg::in_item_t in_item,
  input  wire logic [63:0]       key_high,
  input  wire logic [63:0]       key_low,
  input  wire logic [63:0]       iv_high,
  input  wire logic [63:0]       iv_low,
  output aes_pkg::out_item_t     result
);
  logic [127:0] st;
  logic [127:0] chain;
  logic [127:0] cipher_in;
  logic         dec;
  logic         last;
  logic [127:0] kwin;       // last four schedule words
  logic [5:0]   kidx;       // next schedule word index
  logic [aes_pkg::RkAw-1:0] waddr;
  logic [31:0]  wdata;
  logic         we;
  logic [31:0]  rk_word;
  logic [127:0] rk;
  logic [1:0]   rk_cnt;
  logic [31:0]  new_word;
  logic [31:0]  tmp;
  logic [aes_pkg::RkAw-1:0] raddr;
  logic [127:0] sub_s;
  logic [127:0] shf_s;
  logic [127:0] mix_s;
  logic [127:0] rnd_s;
  logic [127:0] load_s;
  logic [127:0] cbc_chain;

  // next schedule word from the window
  always_comb begin
    tmp = kwin[31:0];
    if (kidx[1:0] == 2'd0) begin
      tmp = aes_pkg::sub_word({tmp[23:0], tmp[31:24]})
          ^ {aes_pkg::RCON[4'(kidx[5:2] - 4'd1)], 24'h0};
    end
    new_word = kwin[127:96] ^ tmp;
  end

  always_ff @(posedge clk) begin
    if (ctl.key_init) begin
      kwin <= {key_high, key_low};
      kidx <= 6'd0;
    end else if (ctl.key_step) begin
      if (kidx < 6'd4) begin
        kidx <= kidx + 6'd1;
      end else begin
        kwin <= {kwin[95:0], new_word};
        kidx <= kidx + 6'd1;
      end
    end
  end

  // words 0..3 written straight from the key registers
  always_comb begin
    waddr = kidx;
    we    = ctl.key_step;
    case (kidx[1:0])
      2'd0:    wdata = kwin[127:96];
      2'd1:    wdata = kwin[95:64];
      2'd2:    wdata = kwin[63:32];
      default: wdata = kwin[31:0];
    endcase
    if (kidx >= 6'd4) begin
      wdata = new_word;
    end
  end

  // four reads per round key, one word a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rk_cnt <= 2'd0;
    end else if (ctl.rk_rd) begin
      rk_cnt <= rk_cnt + 2'd1;
    end
  end

  assign raddr = {ctl.rk_round, rk_cnt};

  aes_ram #(.Width(32), .Depth(aes_pkg::RkDepth)) u_rk (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rk_word)
  );

  logic rd_d;
  always_ff @(posedge clk) begin
    rd_d <= ctl.rk_rd;
    if (rd_d) begin
      rk <= {rk[95:0], rk_word};
    end
  end

  always_comb begin
    for (int n = 0; n < 16; n++) begin
      sub_s[127 - 8*n -: 8] = aes_pkg::sub_byte(st[127 - 8*n -: 8]);
    end
    shf_s = aes_pkg::shift_rows(dec ? st : sub_s, !dec);
    if (dec) begin
      for (int n = 0; n < 16; n++) begin
        shf_s[127 - 8*n -: 8] = aes_pkg::inv_sub_byte(shf_s[127 - 8*n -: 8]);
      end
      shf_s = shf_s ^ rk;
    end
    for (int c = 0; c < 4; c++) begin
      mix_s[127 - 32*c -: 32] = aes_pkg::mix_col(shf_s[127 - 32*c -: 32], !dec);
    end
    if (dec) begin
      rnd_s = ctl.final_rnd ? shf_s : mix_s;
    end else begin
      rnd_s = (ctl.final_rnd ? shf_s : mix_s) ^ rk;
    end
  end

  always_comb begin
    cbc_chain = in_item.restart_chain ? {iv_high, iv_low} : chain;
    load_s = {in_item.data_high, in_item.data_low};
    if (!in_item.mode) begin
      load_s = load_s ^ cbc_chain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= '0;
    end else if (ctl.load) begin
      chain <= cbc_chain;
    end else if (ctl.finish && !dec) begin
      chain <= st;
    end else if (ctl.finish) begin
      chain <= cipher_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      st        <= load_s;
      dec       <= in_item.mode;
      last      <= in_item.last_block;
      cipher_in <= {in_item.data_high, in_item.data_low};
    end else if (ctl.add_first) begin
      st <= st ^ rk;
    end else if (ctl.round_en) begin
      st <= rnd_s;
    end
    if (ctl.finish) begin
      result.result_high <= dec ? st[127:64] ^ chain[127:64] : st[127:64];
      result.result_low  <= dec ? st[63:0] ^ chain[63:0] : st[63:0];
      result.result_last <= last;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/aes_ctrl.sv
// controller: key expansion sequencing, round sequencing and output handshake
`default_nettype none
module aes_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          key_dirty,
  input  wire logic          in_valid,
  input  wire logic          in_mode,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output aes_pkg::ctl_t      ctl
);
  typedef enum logic [2:0] {
    S_IDLE, S_KEY, S_FETCH, S_ROUND, S_DONE
  } state_t;

  state_t     state;
  logic [5:0] kcnt;
  logic [3:0] rnd;      // current round (0 = initial add)
  logic [2:0] phase;    // key word fetch phase
  logic       dec;
  logic       kready;

  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);

  // round key index used for round n (0 = initial add)
  logic [3:0] kround;
  assign kround = dec ? 4'(4'd10 - rnd) : rnd;

  always_comb begin
    ctl          = '0;
    ctl.load     = in_valid && in_ready;
    ctl.key_init = in_valid && in_ready && (!kready || key_dirty);
    ctl.key_step = (state == S_KEY);
    ctl.rk_round = kround;
    ctl.rk_rd    = (state == S_FETCH) && (phase < 3'd4);
    ctl.add_first = (state == S_FETCH) && (phase == 3'd5) && (rnd == 4'd0);
    ctl.round_en  = (state == S_FETCH) && (phase == 3'd5) && (rnd != 4'd0);
    ctl.final_rnd = (rnd == 4'd10);
    ctl.finish    = (state == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kcnt      <= 6'd0;
      rnd       <= 4'd0;
      phase     <= 3'd0;
      dec       <= 1'b0;
      kready    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (key_dirty) begin
        kready <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            dec   <= in_mode;
            rnd   <= 4'd0;
            phase <= 3'd0;
            kcnt  <= 6'd0;
            state <= (!kready || key_dirty) ? S_KEY : S_FETCH;
          end
        end
        S_KEY: begin
          kcnt <= kcnt + 6'd1;
          if (kcnt == 6'(aes_pkg::RkDepth - 1)) begin
            kready <= 1'b1;
            state  <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (phase == 3'd5) begin
            phase <= 3'd0;
            if (rnd == 4'd10) begin
              state <= S_DONE;
            end else begin
              rnd <= rnd + 4'd1;
            end
          end else begin
            phase <= phase + 3'd1;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/aes128_cbc_engine_core.sv
// top level of the aes-128 cbc engine
//
// input channel in_valid/in_ready moves one 128-bit block with mode,
// restart_chain and last_block; output channel out_valid/out_ready returns
// the processed block with result_last.
// configuration: cfg_we, cfg_index, cfg_data write key_high, key_low,
// iv_high, iv_low (index 0 to 3); write only while the engine is idle.
// each block runs from transfer to result through an initial key add and
// ten rounds, each round fetching its four key words one per cycle from
// the round key ram, followed by the cbc xor. the first block after reset
// or a key write first runs the key schedule, one word a cycle.
// blocks are processed one at a time since cbc chains each to the last.
// reset clears the chaining value, the key-valid flag and the configuration registers.
// a stalled receiver holds the result; the next block is taken only once
// the output register is free or is being emptied.
`default_nettype none
module aes128_cbc_engine_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire aes_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output aes_pkg::out_item_t      out_data
);
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [63:0] iv_high;
  logic [63:0] iv_low;
  logic        key_dirty;
  aes_pkg::ctl_t ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high  <= '0;
      key_low   <= '0;
      iv_high   <= '0;
      iv_low    <= '0;
      key_dirty <= 1'b0;
    end else begin
      if (ctl.key_init) begin
        key_dirty <= 1'b0;
      end
      if (cfg_we) begin
        case (aes_pkg::reg_idx_t'(cfg_index))
          aes_pkg::REG_KEY_HIGH: begin
            key_high  <= cfg_data;
            key_dirty <= 1'b1;
          end
          aes_pkg::REG_KEY_LOW: begin
            key_low   <= cfg_data;
            key_dirty <= 1'b1;
          end
          aes_pkg::REG_IV_HIGH: iv_high <= cfg_data;
          aes_pkg::REG_IV_LOW:  iv_low  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  aes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key_dirty (key_dirty),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  aes_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .in_item  (in_data),
    .key_high (key_high),
    .key_low  (key_low),
    .iv_high  (iv_high),
    .iv_low   (iv_low),
    .result   (out_data)
  );
endmodule
`default_nettype wire

FILE: hdl/aes128_cbc_engine_core_checker.sv
// port level checker for the aes128 cbc engine, bound to the top level
`default_nettype none
`include "aes128_cbc_engine_core_macros.svh"
module aes128_cbc_engine_core_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire aes_pkg::out_item_t out_data
);
  `ACE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `ACE_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready, "second block taken while busy")
  `ACE_ASSERT_IMPL(a_no_take_full, clk, rst, out_valid && !out_ready, !in_ready, "block taken with result pending")
endmodule

bind aes128_cbc_engine_core aes128_cbc_engine_core_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
